// ===== design/positional_list_store_defines.svh =====
// ---------------------------------------------------------------------------
// positional_list_store assertion macros
// Shared property forms for the list store checks.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// same-cycle implication, reset masked
`define PLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pls_pkg.sv =====
// ---------------------------------------------------------------------------
// pls_pkg
// Command and status codes, and the control word broadcast to the cell row.
// ---------------------------------------------------------------------------
package pls_pkg;

  // position/count width inside the row control word; covers DEPTH up to 127
  localparam int PTR_W = 7;

  localparam logic [2:0] CMD_INS_AT    = 3'd0;
  localparam logic [2:0] CMD_INS_FRONT = 3'd1;
  localparam logic [2:0] CMD_INS_END   = 3'd2;
  localparam logic [2:0] CMD_DEL_AT    = 3'd3;
  localparam logic [2:0] CMD_DEL_FRONT = 3'd4;
  localparam logic [2:0] CMD_DEL_END   = 3'd5;
  localparam logic [2:0] CMD_DUMP      = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    CK_HOLD,
    CK_INS,
    CK_DEL,
    CK_ROT
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t       kind;
    logic [PTR_W-1:0] pos;
    logic [PTR_W-1:0] cnt;
  } cell_ctl_t;

endpackage

// ===== design/pls_cell.sv =====
// ---------------------------------------------------------------------------
// pls_cell
// One list slot. Holds, loads a new word, or takes a neighbor's or the head's word.
// ---------------------------------------------------------------------------
module pls_cell #(
  parameter int IDX   = 0,
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  pls_pkg::cell_ctl_t ctl,
  input  logic [WIDTH-1:0]   left_i,
  input  logic [WIDTH-1:0]   right_i,
  input  logic [WIDTH-1:0]   head_i,
  input  logic [WIDTH-1:0]   new_i,
  output logic [WIDTH-1:0]   data_o
);
  import pls_pkg::*;

  localparam logic [PTR_W-1:0] MY_IDX  = PTR_W'(IDX);
  localparam logic [PTR_W-1:0] NXT_IDX = PTR_W'(IDX + 1);

  logic [WIDTH-1:0] data_r;
  logic [WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.kind)
      CK_HOLD: data_nxt = data_r;
      CK_INS: begin
        if (MY_IDX == ctl.pos) begin
          data_nxt = new_i;
        end else if (MY_IDX > ctl.pos && MY_IDX <= ctl.cnt) begin
          data_nxt = left_i;
        end
      end
      CK_DEL: begin
        if (MY_IDX >= ctl.pos && NXT_IDX < ctl.cnt) begin
          data_nxt = right_i;
        end
      end
      // dump: rotate the held part down, head wraps to the tail
      CK_ROT: begin
        if (NXT_IDX == ctl.cnt) begin
          data_nxt = head_i;
        end else if (NXT_IDX < ctl.cnt) begin
          data_nxt = right_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ===== design/positional_list_store.sv =====
// ---------------------------------------------------------------------------
// positional_list_store
// Ordered list of up to DEPTH words held in a row of shifting cells.
//
//   channel  direction  words
//   in_*     input      command, position, element
//   out_*    output     status, count, is_empty, read_valid, read_element, last
//
// Edits shift the whole row at once, one word per cycle while idle and not
// stalled. A dump enters its walk state, then emits each held entry from
// cell 0 as the row rotates; the row ends in its original order.
// Output is registered; a stalled out_ready holds the word and blocks input.
// Reset (rst_n low, synchronous) clears the count; cell contents stay.
// ---------------------------------------------------------------------------
`include "positional_list_store_defines.svh"

module positional_list_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_command,
  input  logic [$clog2(DEPTH+1)-1:0]     in_position,
  input  logic [WIDTH-1:0]               in_element,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [$clog2(DEPTH+1)-1:0]     out_count,
  output logic                           out_is_empty,
  output logic                           out_read_valid,
  output logic [WIDTH-1:0]               out_read_element,
  output logic                           out_last
);
  import pls_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] dump_idx_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_is_empty_r;
  logic             out_read_valid_r;
  logic [WIDTH-1:0] out_read_element_r;
  logic             out_last_r;

  logic             slot_free;
  logic             acc;
  logic             out_load;
  logic             is_ins;
  logic             is_del;
  logic [PTR_W-1:0] ins_pos;
  logic [PTR_W-1:0] del_pos;
  logic [PTR_W-1:0] cnt_ext;
  logic [1:0]       edit_status;
  logic [CNT_W-1:0] edit_cnt;
  logic             dump_last;
  cell_ctl_t        ctl;

  logic [WIDTH-1:0] cell_q [DEPTH];

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;
  assign cnt_ext   = PTR_W'(cnt_r);
  assign dump_last = (dump_idx_r + CNT_W'(1)) == cnt_r;
  // a new output word is loaded this cycle
  assign out_load  = (state_r == S_DUMP) ? slot_free :
                     (acc && !(in_command == CMD_DUMP && cnt_r != '0));

  always_comb begin
    is_ins = (in_command == CMD_INS_AT) || (in_command == CMD_INS_FRONT) ||
             (in_command == CMD_INS_END);
    is_del = (in_command == CMD_DEL_AT) || (in_command == CMD_DEL_FRONT) ||
             (in_command == CMD_DEL_END);

    ins_pos = '0;
    if (in_command == CMD_INS_AT) begin
      ins_pos = PTR_W'(in_position);
    end else if (in_command == CMD_INS_END) begin
      ins_pos = cnt_ext;
    end

    del_pos = '0;
    if (in_command == CMD_DEL_AT) begin
      del_pos = PTR_W'(in_position);
    end else if (in_command == CMD_DEL_END) begin
      del_pos = cnt_ext - PTR_W'(1);
    end

    edit_status = ST_OK;
    edit_cnt    = cnt_r;
    ctl.kind    = CK_HOLD;
    ctl.pos     = ins_pos;
    ctl.cnt     = cnt_ext;

    priority if (is_ins) begin
      priority if (ins_pos > cnt_ext) begin
        edit_status = ST_BAD_POS;
      end else if (cnt_r == FULL_CNT) begin
        edit_status = ST_FULL;
      end else begin
        edit_cnt = cnt_r + CNT_W'(1);
        if (acc) begin
          ctl.kind = CK_INS;
        end
      end
    end else if (is_del) begin
      ctl.pos = del_pos;
      priority if (cnt_r == '0) begin
        edit_status = ST_EMPTY;
      end else if (del_pos >= cnt_ext) begin
        edit_status = ST_BAD_POS;
      end else begin
        edit_cnt = cnt_r - CNT_W'(1);
        if (acc) begin
          ctl.kind = CK_DEL;
        end
      end
    end else if (in_command == CMD_DUMP && cnt_r == '0) begin
      edit_status = ST_EMPTY;
    end else begin
      edit_status = ST_OK;
    end

    if (state_r == S_DUMP && slot_free) begin
      ctl.kind = CK_ROT;
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [WIDTH-1:0] left_w;
      logic [WIDTH-1:0] right_w;
      if (g == 0) begin : g_first
        assign left_w = cell_q[g];
      end else begin : g_mid_l
        assign left_w = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_w = cell_q[g];
      end else begin : g_mid_r
        assign right_w = cell_q[g+1];
      end
      pls_cell #(
        .IDX   (g),
        .WIDTH (WIDTH)
      ) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .left_i  (left_w),
        .right_i (right_w),
        .head_i  (cell_q[0]),
        .new_i   (in_element),
        .data_o  (cell_q[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            if (in_command == CMD_DUMP && cnt_r != '0) begin
              state_r    <= S_DUMP;
              dump_idx_r <= '0;
            end else begin
              cnt_r              <= edit_cnt;
              out_valid_r        <= 1'b1;
              out_status_r       <= edit_status;
              out_count_r        <= edit_cnt;
              out_is_empty_r     <= (edit_cnt == '0);
              out_read_valid_r   <= 1'b0;
              out_read_element_r <= '0;
              out_last_r         <= 1'b1;
            end
          end
        end
        S_DUMP: begin
          if (slot_free) begin
            out_valid_r        <= 1'b1;
            out_status_r       <= ST_OK;
            out_count_r        <= cnt_r;
            out_is_empty_r     <= 1'b0;
            out_read_valid_r   <= 1'b1;
            out_read_element_r <= cell_q[0];
            out_last_r         <= dump_last;
            dump_idx_r         <= dump_idx_r + CNT_W'(1);
            if (dump_last) begin
              state_r <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_count        = out_count_r;
  assign out_is_empty     = out_is_empty_r;
  assign out_read_valid   = out_read_valid_r;
  assign out_read_element = out_read_element_r;
  assign out_last         = out_last_r;

  `PLS_ASSERT_NEXT(a_ins_grows, ctl.kind == CK_INS, cnt_r == CNT_W'($past(cnt_r) + 1'b1), "insert did not grow count")
  `PLS_ASSERT_NEXT(a_del_shrinks, ctl.kind == CK_DEL, cnt_r == CNT_W'($past(cnt_r) - 1'b1), "delete did not shrink count")
  `PLS_ASSERT_NOW(a_dump_nonempty, state_r == S_DUMP, cnt_r != '0 && dump_idx_r < cnt_r, "dump walk out of range")
  `PLS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= FULL_CNT, "count above depth")

endmodule
